// ----- rtl/lift_position_pid_defines.svh -----
// ----------------------------------------------------------------------------
// lift_position_pid defines
// Assertion macros shared by the lift position controller checks.
// ----------------------------------------------------------------------------
`ifndef LIFT_POSITION_PID_DEFINES_SVH
`define LIFT_POSITION_PID_DEFINES_SVH

// same-cycle implication, off while reset is low
`define LPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpp check failed");

// next-cycle implication, off while reset is low
`define LPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpp check failed");

`endif

// ----- rtl/lpp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpp_pkg
// Types and constants of the lift position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

  // integral accumulator width
  localparam int IntegralBits = 32;

  // angle wrapping
  localparam int FullTurn   = 36000;
  localparam int TurnBias   = 15 * FullTurn;
  localparam int BiasW      = 21;
  localparam int QuoW       = 5;
  localparam int RecipShift = 36;
  localparam logic [BiasW-1:0] RecipTurn = 21'd1908875;

  // reachable arc and thresholds
  localparam int ArcLow    = 26700;
  localparam int ArcMid    = 13350;
  localparam int ArcTop    = 35900;
  localparam int JumpLimit = 500;
  localparam int IntWindow = 2500;
  localparam int OutLimit  = 10000;
  localparam int MinWindow = 300;
  localparam int HoldErr   = 40;
  localparam int HoldOut   = 1700;

  // pid sum widths
  localparam int ProdIW        = IntegralBits + 17;
  localparam int SumW          = ((ProdIW > 51) ? ProdIW : 51) + 2;
  localparam int ItermLimitLog = 50;
  localparam logic signed [SumW-1:0] ItermMax =
    {{(SumW-ItermLimitLog-1){1'b0}}, 1'b1, {ItermLimitLog{1'b0}}};

  // millivolt scaling: floor(x / 100) as (x * RecipHundred) >> HundredShift
  localparam int HundredShift = 28;
  localparam logic [21:0] RecipHundred = 22'd2684355;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // register reset values
  localparam logic [15:0] GainPReset   = 16'd896;
  localparam logic [15:0] GainIReset   = 16'd0;
  localparam logic [15:0] GainDReset   = 16'd2560;
  localparam logic [13:0] MinDriveReset = 14'd1500;

  typedef enum logic [1:0] {
    RegGainP    = 2'd0,
    RegGainI    = 2'd1,
    RegGainD    = 2'd2,
    RegMinDrive = 2'd3
  } lpp_reg_e;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [13:0] min_drive;
  } lpp_cfg_t;

  typedef struct packed {
    logic signed [16:0] err;
    logic               clear;
  } lpp_item_t;

endpackage

`default_nettype wire

// ----- rtl/lpp_if.sv -----
// ----------------------------------------------------------------------------
// lpp interfaces
// Valid/ready channels of the lift position controller.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] target_centideg;
  logic        [15:0] measured_centideg;

  modport source (output valid, output target_centideg, output measured_centideg,
                  input ready);
  modport sink   (input valid, input target_centideg, input measured_centideg,
                  output ready);
endinterface

interface lpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_mv;
  logic               hold;

  modport source (output valid, output drive_mv, output hold, input ready);
  modport sink   (input valid, input drive_mv, input hold, output ready);
endinterface

interface lpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpp_front.sv -----
// ----------------------------------------------------------------------------
// lpp_front
// Wraps and confines the target, forms the error and the memory clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_front import lpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpp_in_if.sink    item_i,
  output logic      push_valid_o,
  output lpp_item_t push_item_o,
  input  logic      push_ready_i
);

  logic                   adv;
  logic                   push;
  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic [BiasW-1:0]       s1_u_q, s2_u_q;
  logic [15:0]            s1_meas_q, s2_meas_q, s3_meas_q;
  logic [QuoW-1:0]        s2_quo_q;
  logic [15:0]            s3_t_q;
  logic [15:0]            prev_t_q;
  logic                   first_q;
  logic signed [BiasW:0]  biased;
  logic [2*BiasW-1:0]     quo_prod;
  logic [BiasW-1:0]       quo_mul;
  logic [BiasW-1:0]       rem_full;
  logic [15:0]            rem;
  logic [15:0]            t_clamped;
  logic signed [16:0]     t_diff;
  logic signed [16:0]     err;
  logic                   jump;

  assign adv          = !s3_v_q || push_ready_i;
  assign item_i.ready = adv;
  assign push         = s3_v_q && push_ready_i;

  // whole turns added so the value is never negative
  assign biased = (BiasW+1)'(item_i.target_centideg) + (BiasW+1)'(TurnBias);

  // reciprocal quotient is exact over the biased range
  assign quo_prod = (2*BiasW)'(s1_u_q) * (2*BiasW)'(RecipTurn);

  assign quo_mul  = BiasW'(s2_quo_q) * BiasW'(FullTurn);
  assign rem_full = s2_u_q - quo_mul;
  assign rem      = rem_full[15:0];

  always_comb begin
    t_clamped = rem;
    if (rem != 16'd0 && rem < 16'(ArcLow)) begin
      t_clamped = (rem < 16'(ArcMid)) ? 16'd0 : 16'(ArcLow);
    end else if (rem >= 16'(ArcTop)) begin
      t_clamped = 16'(ArcTop);
    end
  end

  assign err    = $signed({1'b0, s3_t_q}) - $signed({1'b0, s3_meas_q});
  assign t_diff = $signed({1'b0, s3_t_q}) - $signed({1'b0, prev_t_q});
  assign jump   = (t_diff > 17'(JumpLimit)) || (t_diff < -17'(JumpLimit));

  assign push_valid_o      = s3_v_q;
  assign push_item_o.err   = err;
  assign push_item_o.clear = first_q || jump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      prev_t_q <= '0;
      first_q  <= 1'b1;
    end else begin
      if (adv) begin
        s1_v_q <= item_i.valid;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
      if (push) begin
        prev_t_q <= s3_t_q;
        first_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_u_q    <= biased[BiasW-1:0];
      s1_meas_q <= item_i.measured_centideg;
      s2_u_q    <= s1_u_q;
      s2_quo_q  <= quo_prod[RecipShift +: QuoW];
      s2_meas_q <= s1_meas_q;
      s3_t_q    <= t_clamped;
      s3_meas_q <= s2_meas_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpp_queue.sv -----
// ----------------------------------------------------------------------------
// lpp_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_queue import lpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  lpp_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output lpp_item_t pop_item_o,
  input  logic      pop_ready_i
);

  lpp_item_t              entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = count_q != (QueuePtrW+1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpp_back.sv -----
// ----------------------------------------------------------------------------
// lpp_back
// Integral and derivative memory, PID products, clamps and millivolt output.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_back import lpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lpp_cfg_t  cfg_i,
  input  logic      pop_valid_i,
  input  lpp_item_t pop_item_i,
  output logic      pop_ready_o,
  lpp_out_if.source result_o
);

  logic adv;
  logic pop;

  // controller memory
  logic signed [16:0]             prev_err_q;
  logic signed [IntegralBits-1:0] integ_q;

  // pop stage
  logic signed [16:0]             pe;
  logic signed [16:0]             e_in;
  logic signed [IntegralBits-1:0] ig;
  logic signed [IntegralBits:0]   isum;
  logic signed [IntegralBits-1:0] isat;
  logic signed [IntegralBits-1:0] integ_new;
  logic                           in_win;
  logic signed [17:0]             d_in;

  logic                           b1_v_q;
  logic signed [16:0]             b1_e_q;
  logic signed [17:0]             b1_d_q;
  logic signed [IntegralBits-1:0] b1_i_q;

  // products
  logic signed [16:0]       gp_s, gi_s, gd_s;
  logic signed [33:0]       pp;
  logic signed [34:0]       dp;
  logic signed [ProdIW-1:0] ip;
  logic                     big_e, small_e;

  logic                     b2_v_q;
  logic signed [33:0]       b2_pp_q;
  logic signed [34:0]       b2_dp_q;
  logic signed [ProdIW-1:0] b2_ip_q;
  logic                     b2_big_q, b2_small_q;

  // sums
  logic signed [SumW-1:0] pd;
  logic signed [SumW-1:0] ipx;
  logic signed [SumW-1:0] ic;

  logic                   b3_v_q;
  logic signed [SumW-1:0] b3_pd_q;
  logic signed [SumW-1:0] b3_ic_q;
  logic                   b3_big_q, b3_small_q;

  logic                   b4_v_q;
  logic signed [SumW-1:0] b4_sum_q;
  logic                   b4_big_q, b4_small_q;

  // scaling and clamp
  logic signed [SumW-1:0] sr;
  logic signed [SumW-1:0] scaled;
  logic signed [14:0]     o_clamp;

  logic                   b5_v_q;
  logic signed [14:0]     b5_o_q;
  logic                   b5_big_q, b5_small_q;

  // minimum drive and hold
  logic signed [14:0] o_mag;
  logic [13:0]        ao;
  logic [13:0]        ao_adj;
  logic [13:0]        mind;
  logic               hold_c;

  logic               b6_v_q;
  logic [13:0]        b6_ao_q;
  logic               b6_neg_q;
  logic               b6_hold_q;

  // millivolts
  logic [20:0]        mv_x;
  logic [42:0]        mv_prod;
  logic [13:0]        mv;
  logic signed [14:0] drive_c;

  logic               out_v_q;
  logic signed [14:0] out_drive_q;
  logic               out_hold_q;

  assign adv         = !out_v_q || result_o.ready;
  assign pop_ready_o = adv;
  assign pop         = adv && pop_valid_i;

  // memory update, cleared first on a target jump or the first tick
  assign e_in   = pop_item_i.err;
  assign pe     = pop_item_i.clear ? '0 : prev_err_q;
  assign ig     = pop_item_i.clear ? '0 : integ_q;
  assign in_win = (e_in < 17'(IntWindow)) && (e_in > -17'(IntWindow));
  assign isum   = (IntegralBits+1)'(ig) + (IntegralBits+1)'(e_in);
  assign d_in   = 18'(e_in) - 18'(pe);

  always_comb begin
    isat = isum[IntegralBits-1:0];
    if (isum[IntegralBits] != isum[IntegralBits-1]) begin
      isat = isum[IntegralBits] ? {1'b1, {(IntegralBits-1){1'b0}}}
                                : {1'b0, {(IntegralBits-1){1'b1}}};
    end
  end

  assign integ_new = in_win ? isat : '0;

  assign gp_s = $signed({1'b0, cfg_i.gain_p});
  assign gi_s = $signed({1'b0, cfg_i.gain_i});
  assign gd_s = $signed({1'b0, cfg_i.gain_d});
  assign pp   = 34'(gp_s) * 34'(b1_e_q);
  assign dp   = 35'(gd_s) * 35'(b1_d_q);
  assign ip   = ProdIW'(gi_s) * ProdIW'(b1_i_q);

  assign big_e   = (b1_e_q > 17'(MinWindow)) || (b1_e_q < -17'(MinWindow));
  assign small_e = (b1_e_q < 17'(HoldErr)) && (b1_e_q > -17'(HoldErr));

  assign pd  = SumW'(b2_pp_q) + SumW'(b2_dp_q);
  assign ipx = SumW'(b2_ip_q);
  assign ic  = (ipx > ItermMax) ? ItermMax : ((ipx < -ItermMax) ? -ItermMax : ipx);

  // divide by 256 truncating toward zero
  assign sr     = b4_sum_q + (b4_sum_q[SumW-1] ? SumW'(255) : SumW'(0));
  assign scaled = sr >>> 8;

  always_comb begin
    o_clamp = 15'(scaled);
    if (scaled > SumW'(OutLimit)) begin
      o_clamp = 15'(OutLimit);
    end else if (scaled < -SumW'(OutLimit)) begin
      o_clamp = -15'(OutLimit);
    end
  end

  assign o_mag = b5_o_q[14] ? -b5_o_q : b5_o_q;
  assign ao    = o_mag[13:0];
  assign mind  = (cfg_i.min_drive > 14'(OutLimit)) ? 14'(OutLimit) : cfg_i.min_drive;

  always_comb begin
    ao_adj = ao;
    if (b5_big_q && ao != '0 && ao < mind) begin
      ao_adj = mind;
    end
  end

  assign hold_c = b5_small_q && (ao_adj < 14'(HoldOut));

  assign mv_x    = {b6_ao_q, 7'd0};
  assign mv_prod = 43'(mv_x) * 43'(RecipHundred);
  assign mv      = mv_prod[HundredShift +: 14];

  always_comb begin
    drive_c = 15'(mv);
    if (b6_hold_q) begin
      drive_c = '0;
    end else if (b6_neg_q) begin
      drive_c = -15'(mv);
    end
  end

  assign result_o.valid    = out_v_q;
  assign result_o.drive_mv = out_drive_q;
  assign result_o.hold     = out_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      b1_v_q     <= 1'b0;
      b2_v_q     <= 1'b0;
      b3_v_q     <= 1'b0;
      b4_v_q     <= 1'b0;
      b5_v_q     <= 1'b0;
      b6_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (pop) begin
        prev_err_q <= e_in;
        integ_q    <= integ_new;
      end
      if (adv) begin
        b1_v_q  <= pop;
        b2_v_q  <= b1_v_q;
        b3_v_q  <= b2_v_q;
        b4_v_q  <= b3_v_q;
        b5_v_q  <= b4_v_q;
        b6_v_q  <= b5_v_q;
        out_v_q <= b6_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_e_q      <= e_in;
      b1_d_q      <= d_in;
      b1_i_q      <= integ_new;
      b2_pp_q     <= pp;
      b2_dp_q     <= dp;
      b2_ip_q     <= ip;
      b2_big_q    <= big_e;
      b2_small_q  <= small_e;
      b3_pd_q     <= pd;
      b3_ic_q     <= ic;
      b3_big_q    <= b2_big_q;
      b3_small_q  <= b2_small_q;
      b4_sum_q    <= b3_pd_q + b3_ic_q;
      b4_big_q    <= b3_big_q;
      b4_small_q  <= b3_small_q;
      b5_o_q      <= o_clamp;
      b5_big_q    <= b4_big_q;
      b5_small_q  <= b4_small_q;
      b6_ao_q     <= ao_adj;
      b6_neg_q    <= b5_o_q[14];
      b6_hold_q   <= hold_c;
      out_drive_q <= drive_c;
      out_hold_q  <= b6_hold_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lift_position_pid.sv -----
// ----------------------------------------------------------------------------
// lift_position_pid
// Position PID for a lift arm: target confinement, PID and motor command.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one control tick (target and measured angle, centidegrees);
//   result_o returns one drive_mv / hold pair per tick, in order.
//   cfg_i writes gain_p, gain_i, gain_d and min_drive by index; it is always
//   ready and should be used only while no tick is in flight.
// Pipeline: a tick passes 3 front stages, the queue, 6 back stages and the
//   output register, the first front stage loading at the transaction edge.
// Throughput: one tick per cycle unless stalled. The back pipeline keeps
//   the derivative and integral memory in its pop stage, so consecutive ticks
//   follow directly; the multipliers and the wide PID sum set the stage count.
// Reset: gains and minimum drive return to their defaults, the memory clears
//   and the first tick after reset clears it again before use.
// Stall: when result_o is not ready the back pipeline freezes, the two-entry
//   queue fills, and then the front stops taking ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module lift_position_pid import lpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpp_in_if.sink    item_i,
  lpp_out_if.source result_o,
  lpp_cfg_if.sink   cfg_i
);

  lpp_cfg_t  cfg_q;
  logic      push_valid, push_ready;
  lpp_item_t push_item;
  logic      pop_valid, pop_ready;
  lpp_item_t pop_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= GainPReset;
      cfg_q.gain_i    <= GainIReset;
      cfg_q.gain_d    <= GainDReset;
      cfg_q.min_drive <= MinDriveReset;
    end else if (cfg_i.valid) begin
      unique case (lpp_reg_e'(cfg_i.index))
        RegGainP:    cfg_q.gain_p    <= cfg_i.data;
        RegGainI:    cfg_q.gain_i    <= cfg_i.data;
        RegGainD:    cfg_q.gain_d    <= cfg_i.data;
        RegMinDrive: cfg_q.min_drive <= cfg_i.data[13:0];
        default:     cfg_q           <= cfg_q;
      endcase
    end
  end

  lpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  lpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  lpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- rtl/lpp_checker.sv -----
// ----------------------------------------------------------------------------
// lpp_checker
// Port-level checks of the lift position controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lift_position_pid_defines.svh"

module lpp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [14:0] drive_mv_i,
  input logic              hold_i
);

  logic [4:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;
  logic       out_stall;
  logic       drive_ok;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_acc   = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign drive_ok  = (drive_mv_i <= 15'sd12800) && (drive_mv_i >= -15'sd12800);

  // ticks taken but not yet returned
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `LPP_ASSERT_IMP(a_hold_zero, clk_i, rst_ni, out_valid_i && hold_i, drive_mv_i == 15'sd0)
  `LPP_ASSERT_IMP(a_drive_range, clk_i, rst_ni, out_valid_i, drive_ok)
  `LPP_ASSERT_IMP(a_no_extra, clk_i, rst_ni, out_valid_i, cnt_q != 5'd0)
  `LPP_ASSERT_NXT(a_out_stall, clk_i, rst_ni, out_stall, out_valid_i && $stable({drive_mv_i, hold_i}))

endmodule

bind lift_position_pid lpp_checker u_lpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .drive_mv_i  (result_o.drive_mv),
  .hold_i      (result_o.hold)
);

`default_nettype wire
